@@ rtl/core/ospm_pkg.sv @@
`timescale 1ns / 1ps

package ospm_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    localparam int BYTE_W  = 8;
    localparam int FOUND_W = 4;

endpackage

@@ rtl/core/ospm_ram.sv @@
`timescale 1ns / 1ps

module ospm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/ordered_segment_payload_matcher.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake          | Fields
// ---------+--------------------+---------------------------------------------------
// input    | in_valid/in_stall  | action, segment_index, byte_position, byte_value,
//          |                    | end_flag
// result   | out_valid/out_stall| matched, segments_found
//
// One item per cycle while the result side does not stall: an input register feeds
// the window compare, and the result register takes the verdict from it.
// The pattern bytes sit in one small RAM per byte position, addressed ahead of
// time with the segment the next item will compare against.
// Reset (rst_n low, asynchronous) empties the segment list and the match state.
// A stalled result holds the whole block; one more item waits in the input register.
module ordered_segment_payload_matcher #(
    parameter int MAX_SEGMENTS    = 8,
    parameter int MAX_SEGMENT_LEN = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  action,
    input  logic [2:0]                  segment_index,
    input  logic [3:0]                  byte_position,
    input  logic [7:0]                  byte_value,
    input  logic                        end_flag,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        matched,
    output logic [3:0]                  segments_found
);

    localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int LEN_W     = $clog2(MAX_SEGMENT_LEN + 1);
    localparam int BW        = ospm_pkg::BYTE_W;

    typedef logic [LEN_W-1:0] len_arr_t [MAX_SEGMENTS];
    typedef logic [BW-1:0]    win_t     [MAX_SEGMENT_LEN];

    // input register
    logic                  s1_valid_reg;
    ospm_pkg::action_t     s1_action_reg;
    logic [2:0]            s1_seg_reg;
    logic [3:0]            s1_pos_reg;
    logic [BW-1:0]         s1_byte_reg;
    logic                  s1_end_reg;

    // match state
    len_arr_t              lens_reg, lens_next;
    logic [SEG_CNT_W-1:0]  total_reg, total_next;
    logic [SEG_CNT_W-1:0]  cur_reg, cur_next;
    logic [SEG_CNT_W-1:0]  eff_reg, eff_next;
    logic [LEN_W-1:0]      bsm_reg, bsm_next;
    win_t                  win_reg, win_next, win_new;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  matched_reg;
    logic [3:0]            found_reg;

    logic                  advance;
    logic                  load_ok;
    logic                  emit;
    logic [LEN_W-1:0]      bsm_new;
    logic [LEN_W-1:0]      len_eff;
    logic                  seg_hit;
    logic [SEG_CNT_W-1:0]  cur_after;
    logic [SEG_IDX_W-1:0]  ram_waddr;
    logic [SEG_IDX_W-1:0]  ram_raddr;

    logic [MAX_SEGMENT_LEN-1:0] ram_we;
    logic [MAX_SEGMENT_LEN-1:0] hit_reg;
    logic [BW-1:0]              byp_data_reg;
    logic [BW-1:0]              ram_rdata [MAX_SEGMENT_LEN];
    logic [BW-1:0]              pat       [MAX_SEGMENT_LEN];
    logic [MAX_SEGMENT_LEN-1:0] byte_ok;

    // first segment at or after cur that is non-empty, else the end of the list
    function automatic logic [SEG_CNT_W-1:0] skip_empty(
        input logic [SEG_CNT_W-1:0] cur,
        input len_arr_t             lens,
        input logic [SEG_CNT_W-1:0] total
    );
        logic [SEG_CNT_W-1:0] res;
        logic                 found;
        res   = (cur >= total) ? cur : total;
        found = 1'b0;
        for (int s = 0; s < MAX_SEGMENTS; s++)
        begin
            if (!found && SEG_CNT_W'(s) >= cur && SEG_CNT_W'(s) < total && lens[s] != '0)
            begin
                res   = SEG_CNT_W'(s);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    assign advance  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !advance;

    assign load_ok = advance && (s1_action_reg == ospm_pkg::ACT_LOAD)
                     && (32'(s1_seg_reg) < MAX_SEGMENTS)
                     && (32'(s1_pos_reg) < MAX_SEGMENT_LEN);

    assign ram_waddr = SEG_IDX_W'(s1_seg_reg);
    assign ram_raddr = eff_next[SEG_IDX_W-1:0];

    genvar b;
    generate
        for (b = 0; b < MAX_SEGMENT_LEN; b++)
        begin : g_bank
            assign ram_we[b] = load_ok && (32'(s1_pos_reg) == b);

            ospm_ram #(
                .WIDTH (BW),
                .DEPTH (MAX_SEGMENTS)
            ) u_bank (
                .clk   (clk),
                .we    (ram_we[b]),
                .waddr (ram_waddr),
                .wdata (s1_byte_reg),
                .raddr (ram_raddr),
                .rdata (ram_rdata[b])
            );

            // forward a byte written to the row being read in the same cycle
            assign pat[b] = hit_reg[b] ? byp_data_reg : ram_rdata[b];
        end
    endgenerate

    // window after shifting in the new byte
    always_comb
    begin
        win_new[0] = s1_byte_reg;
        for (int i = 1; i < MAX_SEGMENT_LEN; i++)
        begin
            win_new[i] = win_reg[i-1];
        end
    end

    assign bsm_new = (32'(bsm_reg) < MAX_SEGMENT_LEN) ? bsm_reg + LEN_W'(1) : bsm_reg;
    assign len_eff = lens_reg[eff_reg[SEG_IDX_W-1:0]];

    // pattern byte i lines up with window entry len-1-i
    always_comb
    begin
        logic [BW-1:0] sel;
        for (int i = 0; i < MAX_SEGMENT_LEN; i++)
        begin
            sel = '0;
            for (int j = 0; j < MAX_SEGMENT_LEN; j++)
            begin
                if (32'(len_eff) == i + j + 1)
                begin
                    sel = win_new[j];
                end
            end
            byte_ok[i] = (32'(len_eff) <= i) || (pat[i] == sel);
        end
    end

    assign seg_hit = (eff_reg < total_reg) && (bsm_new >= len_eff) && (&byte_ok);

    assign cur_after = seg_hit ? skip_empty(eff_reg + SEG_CNT_W'(1), lens_reg, total_reg)
                               : eff_reg;

    always_comb
    begin
        lens_next  = lens_reg;
        total_next = total_reg;
        cur_next   = cur_reg;
        bsm_next   = bsm_reg;
        win_next   = win_reg;
        emit       = 1'b0;
        if (advance)
        begin
            unique case (s1_action_reg)
                ospm_pkg::ACT_LOAD:
                begin
                    if (load_ok && s1_end_reg)
                    begin
                        lens_next[SEG_IDX_W'(s1_seg_reg)] = LEN_W'(s1_pos_reg) + LEN_W'(1);
                        if (total_reg < SEG_CNT_W'(s1_seg_reg) + SEG_CNT_W'(1))
                        begin
                            total_next = SEG_CNT_W'(s1_seg_reg) + SEG_CNT_W'(1);
                        end
                    end
                end
                ospm_pkg::ACT_DATA:
                begin
                    win_next = win_new;
                    bsm_next = seg_hit ? '0 : bsm_new;
                    cur_next = cur_after;
                    if (s1_end_reg)
                    begin
                        emit     = 1'b1;
                        cur_next = '0;
                        bsm_next = '0;
                    end
                end
                ospm_pkg::ACT_CLEAR:
                begin
                    for (int s = 0; s < MAX_SEGMENTS; s++)
                    begin
                        lens_next[s] = '0;
                    end
                    total_next = '0;
                    cur_next   = '0;
                    bsm_next   = '0;
                end
                ospm_pkg::ACT_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
        eff_next = skip_empty(cur_next, lens_next, total_next);
    end

    assign out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            cur_reg       <= '0;
            eff_reg       <= '0;
            bsm_reg       <= '0;
            hit_reg       <= '0;
            for (int s = 0; s < MAX_SEGMENTS; s++)
            begin
                lens_reg[s] <= '0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            lens_reg      <= lens_next;
            total_reg     <= total_next;
            cur_reg       <= cur_next;
            eff_reg       <= eff_next;
            bsm_reg       <= bsm_next;
            for (int i = 0; i < MAX_SEGMENT_LEN; i++)
            begin
                hit_reg[i] <= ram_we[i] && (ram_waddr == ram_raddr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_action_reg <= ospm_pkg::action_t'(action);
            s1_seg_reg    <= segment_index;
            s1_pos_reg    <= byte_position;
            s1_byte_reg   <= byte_value;
            s1_end_reg    <= end_flag;
        end
        if (emit)
        begin
            matched_reg <= (cur_after >= total_reg);
            found_reg   <= ospm_pkg::FOUND_W'(cur_after);
        end
        win_reg      <= win_next;
        byp_data_reg <= s1_byte_reg;
    end

    assign out_valid      = out_valid_reg;
    assign matched        = matched_reg;
    assign segments_found = found_reg;

endmodule

@@ sim/ospm_verdict_checker.sv @@
`timescale 1ns / 1ps

module ospm_verdict_checker #(
    parameter int MAX_SEGMENTS    = 8,
    parameter int MAX_SEGMENT_LEN = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] action,
    input  logic [2:0] segment_index,
    input  logic [3:0] byte_position,
    input  logic [7:0] byte_value,
    input  logic       end_flag,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       matched,
    input  logic [3:0] segments_found,
    output int         error_count,
    output int         pending
);

    typedef struct packed {
        logic                         matched;
        logic [ospm_pkg::FOUND_W-1:0] found;
    } verdict_t;

    logic [ospm_pkg::BYTE_W-1:0] pattern_mem [MAX_SEGMENTS*MAX_SEGMENT_LEN];
    int                          seg_len [MAX_SEGMENTS];
    int                          seg_count;
    int                          cur_seg;
    logic [ospm_pkg::BYTE_W-1:0] window [MAX_SEGMENT_LEN];
    int                          fresh_bytes;
    verdict_t                    verdict_q [$];
    int                          result_no;

    task automatic report_mismatch(input string msg);
        $display("ospm_verdict_checker: result %0d: %s", result_no, msg);
        error_count++;
    endtask

    task automatic restart_search();
        cur_seg = 0;
        fresh_bytes = 0;
        for (int i = 0; i < MAX_SEGMENT_LEN; i++)
            window[i] = '0;
    endtask

    task automatic skip_empty();
        while (cur_seg < seg_count && cur_seg < MAX_SEGMENTS && seg_len[cur_seg] == 0)
            cur_seg++;
    endtask

    // Oldest window byte lines up with the first pattern byte.
    function automatic bit window_hit(input int seg, input int len);
        for (int i = 0; i < len; i++)
        begin
            if (pattern_mem[seg*MAX_SEGMENT_LEN + i] !== window[len-1-i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic advance_matcher(input ospm_pkg::action_t act, input logic [2:0] seg,
                                   input logic [3:0] pos, input logic [7:0] val,
                                   input logic last);
        int       s;
        int       p;
        int       len;
        verdict_t v;
        s = int'(seg);
        p = int'(pos);
        case (act)
            ospm_pkg::ACT_LOAD:
            begin
                if (s < MAX_SEGMENTS && p < MAX_SEGMENT_LEN)
                begin
                    pattern_mem[s*MAX_SEGMENT_LEN + p] = val;
                    if (last)
                    begin
                        seg_len[s] = p + 1;
                        if (seg_count < s + 1)
                            seg_count = s + 1;
                    end
                end
            end
            ospm_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < MAX_SEGMENTS; i++)
                    seg_len[i] = 0;
                seg_count = 0;
                restart_search();
            end
            ospm_pkg::ACT_DATA:
            begin
                for (int i = MAX_SEGMENT_LEN - 1; i > 0; i--)
                    window[i] = window[i-1];
                window[0] = val;
                if (fresh_bytes < MAX_SEGMENT_LEN)
                    fresh_bytes++;
                skip_empty();
                if (cur_seg < seg_count && cur_seg < MAX_SEGMENTS)
                begin
                    len = seg_len[cur_seg];
                    if (fresh_bytes >= len && window_hit(cur_seg, len))
                    begin
                        cur_seg++;
                        fresh_bytes = 0;
                        skip_empty();
                    end
                end
                if (last)
                begin
                    v.matched = (cur_seg >= seg_count);
                    v.found   = cur_seg[ospm_pkg::FOUND_W-1:0];
                    verdict_q = {verdict_q, v};
                    restart_search();
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (verdict_q.size() == 0)
        begin
            report_mismatch("result with none expected");
        end
        else
        begin
            want = verdict_q.pop_front();
            if (matched !== want.matched)
                report_mismatch($sformatf("matched %b, want %b", matched, want.matched));
            if (segments_found !== want.found)
                report_mismatch($sformatf("segments_found %0d, want %0d",
                                          segments_found, want.found));
        end
        result_no++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
                seg_len[i] = 0;
            seg_count = 0;
            restart_search();
            verdict_q.delete();
            result_no = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_verdict();
            if (in_valid && !in_stall)
                advance_matcher(ospm_pkg::action_t'(action), segment_index, byte_position,
                                byte_value, end_flag);
            pending = verdict_q.size();
        end
    end

endmodule

@@ sim/tb_ordered_segment_payload_matcher.sv @@
`timescale 1ns / 1ps

module tb_ordered_segment_payload_matcher;

    localparam int SEGS         = 8;
    localparam int SEG_LEN      = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [1:0] action        = ospm_pkg::ACT_NOP;
    logic [2:0] segment_index = '0;
    logic [3:0] byte_position = '0;
    logic [7:0] byte_value    = '0;
    logic       end_flag      = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic       matched;
    logic [3:0] segments_found;

    int error_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    int item_count  = 0;
    bit send_burst  = 1'b0;
    bit recv_burst  = 1'b0;
    bit took_result = 1'b0;

    // table as the stimulus sees it, used to build buffers that match
    logic [7:0]         gen_bytes [SEGS][SEG_LEN];
    int                 gen_len [SEGS];
    int                 gen_total = 0;
    logic [SEG_LEN-1:0] filled [SEGS];

    ordered_segment_payload_matcher #(
        .MAX_SEGMENTS   (SEGS),
        .MAX_SEGMENT_LEN(SEG_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .segment_index (segment_index),
        .byte_position (byte_position),
        .byte_value    (byte_value),
        .end_flag      (end_flag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .matched       (matched),
        .segments_found(segments_found)
    );

    ospm_verdict_checker #(
        .MAX_SEGMENTS   (SEGS),
        .MAX_SEGMENT_LEN(SEG_LEN)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .segment_index (segment_index),
        .byte_position (byte_position),
        .byte_value    (byte_value),
        .end_flag      (end_flag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .matched       (matched),
        .segments_found(segments_found),
        .error_count   (error_count),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_ordered_segment_payload_matcher: errors");
            $finish;
        end
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    always @(posedge clk)
    begin
        took_result <= rst_n && out_valid && !out_stall;
    end

    // Result side: hold stall for a drawn number of cycles per result.
    always @(negedge clk)
    begin
        if (took_result)
        begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall_left = draw_gap(recv_burst);
        end
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            if (out_valid)
                stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    task automatic send_item(input ospm_pkg::action_t act, input logic [2:0] seg,
                             input logic [3:0] pos, input logic [7:0] val,
                             input logic last);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action        = act;
        segment_index = seg;
        byte_position = pos;
        byte_value    = val;
        end_flag      = last;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (act != ospm_pkg::ACT_NOP)
            item_count++;
        if ($urandom_range(0, 59) == 0)
            send_burst = !send_burst;
    endtask

    // End a segment only once every byte below it has been written.
    task automatic load_byte(input logic [2:0] seg, input logic [3:0] pos,
                             input logic [7:0] val, input logic last);
        int   need;
        logic ok_end;
        need   = (1 << (pos + 1)) - 1;
        ok_end = last && (((filled[seg] | (16'h1 << pos)) & need[15:0]) == need[15:0]);
        send_item(ospm_pkg::ACT_LOAD, seg, pos, val, ok_end);
        filled[seg][pos]    = 1'b1;
        gen_bytes[seg][pos] = val;
        if (ok_end)
        begin
            gen_len[seg] = pos + 1;
            if (gen_total < seg + 1)
                gen_total = seg + 1;
        end
    endtask

    task automatic data_byte(input logic [7:0] val, input logic last);
        send_item(ospm_pkg::ACT_DATA, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  val, last);
    endtask

    task automatic clear_table();
        send_item(ospm_pkg::ACT_CLEAR, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (int s = 0; s < SEGS; s++)
            gen_len[s] = 0;
        gen_total = 0;
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // A small alphabet makes partial and repeated matches common.
    function automatic logic [7:0] pick_byte(input bit narrow);
        if (!narrow)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'hA5;
            default: return 8'h5A;
        endcase
    endfunction

    task automatic noise_item();
        case ($urandom_range(0, 5))
            0, 1: load_byte(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            2:    send_item(ospm_pkg::ACT_NOP, 3'($urandom_range(0, 7)),
                            4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            3:    if ($urandom_range(0, 3) == 0)
                      clear_table();
                  else
                      data_byte(8'($urandom_range(0, 255)), 1'b1);
            default: data_byte(pick_byte(1'($urandom_range(0, 1))),
                               $urandom_range(0, 7) == 0);
        endcase
    endtask

    task automatic build_table(input bit narrow);
        int n;
        int len;
        if ($urandom_range(0, 4) != 0)
            clear_table();
        n = $urandom_range(0, SEGS);
        for (int s = 0; s < n; s++)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                len = ($urandom_range(0, 19) == 0) ? SEG_LEN : $urandom_range(1, 4);
                for (int p = 0; p < len; p++)
                    load_byte(3'(s), 4'(p), pick_byte(narrow), p == len - 1);
            end
        end
    endtask

    task automatic send_buffer(input bit narrow);
        logic [7:0] stream [$];
        int         fill;
        int         idx;
        for (int s = 0; s < gen_total; s++)
        begin
            fill = $urandom_range(0, 3);
            repeat (fill) stream = {stream, pick_byte(narrow)};
            // drop a segment now and then
            if ($urandom_range(0, 5) != 0)
            begin
                for (int p = 0; p < gen_len[s]; p++)
                    stream = {stream, gen_bytes[s][p]};
            end
        end
        fill = $urandom_range(0, 2);
        repeat (fill) stream = {stream, pick_byte(narrow)};
        if (stream.size() == 0)
            stream = {stream, pick_byte(narrow)};
        if ($urandom_range(0, 7) == 0)
        begin
            idx = $urandom_range(0, stream.size() - 1);
            stream[idx] = stream[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        for (int i = 0; i < stream.size(); i++)
        begin
            if ($urandom_range(0, 29) == 0)
                noise_item();
            data_byte(stream[i], i == stream.size() - 1);
        end
    endtask

    initial
    begin
        int next_hold;
        int buffers;
        bit narrow;
        for (int s = 0; s < SEGS; s++)
        begin
            filled[s]  = '0;
            gen_len[s] = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list matches
        data_byte(8'h00, 1'b1);
        send_item(ospm_pkg::ACT_NOP, 3'h7, 4'hF, 8'hFF, 1'b1);
        load_byte(3'd0, 4'd0, 8'h00, 1'b0);
        load_byte(3'd0, 4'd1, 8'hFF, 1'b1);
        // segment 1 and segments 3 to 6 stay empty
        load_byte(3'd2, 4'd0, 8'h5A, 1'b1);
        load_byte(3'd7, 4'd0, 8'h80, 1'b1);
        data_byte(8'h00, 1'b0);
        data_byte(8'hFF, 1'b0);
        data_byte(8'h5A, 1'b0);
        data_byte(8'h80, 1'b1);
        // wrong order finds nothing
        data_byte(8'h5A, 1'b1);
        clear_table();
        data_byte(8'hFF, 1'b1);
        // equal neighbors need a byte each
        load_byte(3'd0, 4'd0, 8'hAA, 1'b1);
        load_byte(3'd1, 4'd0, 8'hAA, 1'b1);
        data_byte(8'hAA, 1'b1);
        data_byte(8'hAA, 1'b0);
        data_byte(8'hAA, 1'b1);
        wait_for_results();

        item_count = 0;
        next_hold  = 400;
        while (item_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                narrow = 1'($urandom_range(0, 1));
                build_table(narrow);
                buffers = $urandom_range(1, 4);
                repeat (buffers) send_buffer(narrow);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) noise_item();
            end
            if (item_count >= next_hold)
            begin
                wait_for_results();
                next_hold += 400;
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && pending == 0)
            $display("tb_ordered_segment_payload_matcher: clean");
        else
            $display("tb_ordered_segment_payload_matcher: errors");
        $finish;
    end

endmodule
